FILE: rtl/core/cdfb_pkg.sv
// Shared types, constants and lamp code mapping for the countdown frame builder.
package cdfb_pkg;

    localparam int MAX_DEVICES = 32;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [2:0] BLINK_FLAG = 3'(1 << 2);
    localparam int         ID_SHIFT   = 3;

    localparam int CNT_W  = 6;
    localparam int ID_W   = 5;
    localparam int TIME_W = 8;
    localparam int LAMP_W = 3;
    localparam int LIM_W  = 16;
    localparam int S_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_DEVICE = 2'd1,
        OP_END    = 2'd2
    } t_op;

    typedef enum logic {
        CFG_LIMIT_ENABLE     = 1'b0,
        CFG_FREE_GREEN_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        LAMP_OFF          = 3'd0,
        LAMP_GREEN        = 3'd1,
        LAMP_RED          = 3'd2,
        LAMP_YELLOW       = 3'd3,
        LAMP_GREEN_BLINK  = 3'd4,
        LAMP_YELLOW_BLINK = 3'd5
    } t_lamp;

    localparam logic [1:0] CODE_OFF    = 2'd0;
    localparam logic [1:0] CODE_GREEN  = 2'd1;
    localparam logic [1:0] CODE_YELLOW = 2'd2;
    localparam logic [1:0] CODE_RED    = 2'd3;

    function automatic logic [2:0] color_bits(input logic [LAMP_W-1:0] lamp);
        logic [2:0] res;
        unique case (lamp)
            LAMP_GREEN:        res = {1'b0, CODE_GREEN};
            LAMP_RED:          res = {1'b0, CODE_RED};
            LAMP_YELLOW:       res = {1'b0, CODE_YELLOW};
            LAMP_GREEN_BLINK:  res = BLINK_FLAG | {1'b0, CODE_GREEN};
            LAMP_YELLOW_BLINK: res = BLINK_FLAG | {1'b0, CODE_YELLOW};
            default:           res = {1'b0, CODE_OFF};
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/countdown_display_frame_builder.sv
// Top level: countdown display frame builder with a two-entry byte burst buffer.
// An accepted word is registered into the active burst register, or into the pending one.
// Throughput: one input word per cycle while words cause no bytes and none wait; otherwise the
// byte-wide master port sets the pace: 3 bytes per start, 2 per enabled device, 1 per end.
// A pending burst register lets the next word enter while the current burst drains.
// Reset: synchronous, active low; clears bursts, checksum and both config registers.
module countdown_display_frame_builder
    import cdfb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [LIM_W-1:0]    i_cfg_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [5:0] device_count, [6] slot_enabled, [11:7] device_id,
    // [19:12] remaining_time, [22:20] lamp_color, [23] zero
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [1:0] op
    input  logic [1:0]          i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [7:0] out_byte
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast,
    // [0] frame_end
    output logic                o_m_tuser
);

    logic              r_limit_en;
    logic [LIM_W-1:0]  r_limit;
    logic [7:0]        r_xor, n_xor;

    logic [23:0]       r_pend_data, r_act_data;
    logic [1:0]        r_pend_left, r_act_left;
    logic              r_pend_fend, r_act_fend;

    logic [CNT_W-1:0]  in_cnt;
    logic              in_slot;
    logic [ID_W-1:0]   in_id;
    logic [TIME_W-1:0] in_time;
    logic [LAMP_W-1:0] in_lamp;
    t_op               in_op;

    logic [7:0]        cnt_sat, b0, t_out;
    logic [2:0]        code;
    logic [23:0]       new_data;
    logic [1:0]        new_left;
    logic              new_fend;
    logic              accept, act_free, pend_valid, new_valid;

    assign in_cnt  = i_s_tdata[5:0];
    assign in_slot = i_s_tdata[6];
    assign in_id   = i_s_tdata[11:7];
    assign in_time = i_s_tdata[19:12];
    assign in_lamp = i_s_tdata[22:20];
    assign in_op   = t_op'(i_s_tuser);

    assign pend_valid = (r_pend_left != 2'd0);
    assign act_free   = (r_act_left == 2'd0) || (i_m_tready && r_act_left == 2'd1);
    assign o_s_tready = !pend_valid || act_free;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        cnt_sat = (in_cnt > CNT_W'(MAX_DEVICES)) ? 8'(MAX_DEVICES) : 8'(in_cnt);
        code    = color_bits(in_lamp);
        t_out   = in_time;
        if (r_limit_en && (r_limit < LIM_W'(in_time))) begin
            code  = 3'd0;
            t_out = 8'd0;
        end
        b0 = {in_id, code};
    end

    always_comb begin
        new_data = 24'd0;
        new_left = 2'd0;
        new_fend = 1'b0;
        n_xor    = r_xor;
        unique case (in_op)
            OP_START: begin
                new_data = {cnt_sat, HDR_SECOND, HDR_FIRST};
                new_left = 2'd3;
                n_xor    = cnt_sat;
            end
            OP_DEVICE: begin
                if (in_slot) begin
                    new_data = {8'd0, t_out, b0};
                    new_left = 2'd2;
                    n_xor    = r_xor ^ b0 ^ t_out;
                end
            end
            OP_END: begin
                new_data = {16'd0, r_xor};
                new_left = 2'd1;
                new_fend = 1'b1;
            end
            default: begin
                new_left = 2'd0;
            end
        endcase
        new_valid = accept && (new_left != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_en <= 1'b0;
            r_limit    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LIMIT_ENABLE:     r_limit_en <= i_cfg_data[0];
                CFG_FREE_GREEN_LIMIT: r_limit    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor <= 8'd0;
        end else if (accept) begin
            r_xor <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_left  <= 2'd0;
            r_pend_left <= 2'd0;
        end else begin
            if (act_free) begin
                if (pend_valid) begin
                    r_act_left  <= r_pend_left;
                    r_pend_left <= new_valid ? new_left : 2'd0;
                end else begin
                    r_act_left  <= new_valid ? new_left : 2'd0;
                end
            end else begin
                if (i_m_tready) begin
                    r_act_left <= r_act_left - 2'd1;
                end
                if (new_valid) begin
                    r_pend_left <= new_left;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (act_free) begin
            if (pend_valid) begin
                r_act_data <= r_pend_data;
                r_act_fend <= r_pend_fend;
                if (new_valid) begin
                    r_pend_data <= new_data;
                    r_pend_fend <= new_fend;
                end
            end else if (new_valid) begin
                r_act_data <= new_data;
                r_act_fend <= new_fend;
            end
        end else begin
            if (i_m_tready) begin
                r_act_data <= {8'd0, r_act_data[23:8]};
            end
            if (new_valid) begin
                r_pend_data <= new_data;
                r_pend_fend <= new_fend;
            end
        end
    end

    assign o_m_tvalid = (r_act_left != 2'd0);
    assign o_m_tdata  = r_act_data[7:0];
    assign o_m_tlast  = (r_act_left == 2'd1);
    assign o_m_tuser  = r_act_fend && (r_act_left == 2'd1);

endmodule

FILE: rtl/core/cdfb_checker.sv
// Port-level checker for the countdown frame builder, bound to the top level.
module cdfb_checker
    import cdfb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [1:0]          i_s_tuser,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [7:0]          o_m_tdata,
    input logic                o_m_tlast,
    input logic                o_m_tuser
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("master word changed while stalled");

    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("frame end without run last");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("master valid after reset");

    a_start_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == OP_START && !o_m_tvalid)
            |=> (o_m_tvalid && o_m_tdata == HDR_FIRST && !o_m_tlast))
        else $error("start word did not open with header byte");

    a_end_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == OP_END && !o_m_tvalid)
            |=> (o_m_tvalid && o_m_tlast && o_m_tuser))
        else $error("end word did not give a closing checksum byte");

endmodule

bind countdown_display_frame_builder cdfb_checker u_cdfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
